@@ design/toroidal_traffic_automaton_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the toroidal traffic automaton checker
// Clock i_clk and active-low reset i_rst_n are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_TRAFFIC_AUTOMATON_MACROS_SVH
`define TOROIDAL_TRAFFIC_AUTOMATON_MACROS_SVH

// same-cycle implication
`define TTA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("toroidal_traffic_automaton: same-cycle check failed");

// next-cycle implication
`define TTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("toroidal_traffic_automaton: next-cycle check failed");

`endif

@@ design/tta_pkg.sv @@
// ----------------------------------------------------------------------------
// tta_pkg
// Sizes, cell codes, register indexes and helpers for the traffic automaton.
// ----------------------------------------------------------------------------
package tta_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int LEN_W    = $clog2(MAX_DIM + 1);
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int POS_W    = $clog2(CELLS);
    localparam int DIM_CFG_W = 9;
    localparam int LIM_W     = 21;
    localparam int CFG_W     = 21;

    typedef logic [1:0] t_cell;
    localparam t_cell CELL_EMPTY = 2'd0;
    localparam t_cell CELL_EAST  = 2'd1;
    localparam t_cell CELL_SOUTH = 2'd2;
    localparam t_cell CELL_BAD   = 2'd3;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COLS  = 2'd0;
    localparam t_cfg_idx CFG_ROWS  = 2'd1;
    localparam t_cfg_idx CFG_LIMIT = 2'd2;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quo;
        logic [LEN_W-1:0] rem;
    } t_div_res;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [DIM_CFG_W-1:0] v,
                                                   input int maxv);
        if (v == '0) begin
            return LEN_W'(1);
        end else if (int'(v) > maxv) begin
            return LEN_W'(maxv);
        end
        return LEN_W'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        return ADDR_W'(int'(row) * MAX_COLS + int'(col));
    endfunction

    // new value of the center cell of a three-cell window along the move axis
    function automatic t_cell next_cell(input t_cell l, input t_cell c, input t_cell r,
                                        input t_cell mover);
        if (c == mover && r == CELL_EMPTY) begin
            return CELL_EMPTY;
        end else if (c == CELL_EMPTY && l == mover) begin
            return mover;
        end
        return c;
    endfunction

endpackage

@@ design/tta_divider.sv @@
// ----------------------------------------------------------------------------
// tta_divider
// Restoring divider, one quotient bit per cycle; maps the linear load
// position to row and column after a grid size change.
// ----------------------------------------------------------------------------
module tta_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tta_pkg::POS_W-1:0] i_dividend,
    input  logic [tta_pkg::LEN_W-1:0] i_divisor,
    output tta_pkg::t_div_res         o_res
);

    localparam int CNT_W = $clog2(tta_pkg::POS_W + 1);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [tta_pkg::POS_W-1:0] r_quo;
    logic [tta_pkg::LEN_W-1:0] r_rem;

    logic [tta_pkg::LEN_W:0]   shifted;
    logic [tta_pkg::LEN_W:0]   diff;
    logic                      ge;

    assign shifted = {r_rem, r_quo[tta_pkg::POS_W-1]};
    assign ge      = shifted >= (tta_pkg::LEN_W + 1)'(i_divisor);
    assign diff    = shifted - (tta_pkg::LEN_W + 1)'(i_divisor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(tta_pkg::POS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[tta_pkg::POS_W-2:0], ge};
            r_rem <= ge ? diff[tta_pkg::LEN_W-1:0] : shifted[tta_pkg::LEN_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

@@ design/toroidal_traffic_automaton.sv @@
// ----------------------------------------------------------------------------
// toroidal_traffic_automaton
// Load transfers: one per cycle while busy is low, no result, busy stays low.
// Run transfer: busy while it steps the R x C grid, up to the step limit or until a
// step moves nothing; lines go through the single cell memory read port; result strobe follows.
// Write to grid_cols or grid_rows: busy while the position divider runs.
// Reset (sync, active low) clears control and sets config to its defaults; the grid is not cleared.
// ----------------------------------------------------------------------------
module toroidal_traffic_automaton (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [1:0]                    i_cell_req,
    input  logic                          i_cfg_we,
    input  tta_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [tta_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_done,
    output logic [tta_pkg::LIM_W-1:0]     o_steps,
    output logic                          o_limit_hit
);

    localparam int IDX_W = tta_pkg::IDX_W;
    localparam int LEN_W = tta_pkg::LEN_W;
    localparam int POS_W = tta_pkg::POS_W;
    localparam int LIM_W = tta_pkg::LIM_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RECALC = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_TAIL   = 3'd4;

    localparam logic PH_EAST  = 1'b0;
    localparam logic PH_SOUTH = 1'b1;

    // configuration
    logic [tta_pkg::DIM_CFG_W-1:0] r_grid_cols;
    logic [tta_pkg::DIM_CFG_W-1:0] r_grid_rows;
    logic [LIM_W-1:0]              r_step_limit;

    // control
    logic [2:0]          r_state, n_state;
    logic                r_phase, n_phase;
    logic [IDX_W-1:0]    r_line, n_line;
    logic [LEN_W-1:0]    r_k, n_k;
    logic                r_rv;
    logic [LEN_W-1:0]    r_rk;
    tta_pkg::t_cell      r_wl, n_wl;
    tta_pkg::t_cell      r_wc, n_wc;
    tta_pkg::t_cell      r_save0, n_save0;
    logic [LIM_W-1:0]    r_step_cnt, n_step_cnt;
    logic                r_moved, n_moved;
    logic                r_done, n_done;
    logic [IDX_W-1:0]    r_load_row, n_load_row;
    logic [IDX_W-1:0]    r_load_col, n_load_col;
    logic [POS_W-1:0]    r_load_pos, n_load_pos;

    // memory
    tta_pkg::t_cell              mem [tta_pkg::CELLS];
    tta_pkg::t_cell              r_q;
    logic                        rd_en;
    logic [tta_pkg::ADDR_W-1:0]  rd_addr;
    logic                        mem_we;
    logic [tta_pkg::ADDR_W-1:0]  mem_wa;
    tta_pkg::t_cell              mem_wd;

    // derived
    logic [LEN_W-1:0]    cols_e, rows_e, cols_m1, rows_m1;
    logic [LIM_W-1:0]    limit_e;
    logic [LEN_W-1:0]    line_len, line_cnt, len_m1, cnt_m1, k_m1, rk_m2;
    logic [IDX_W-1:0]    rd_idx;
    tta_pkg::t_cell      mover;
    logic                accept, size_wr;

    logic                win_en, win_we;
    tta_pkg::t_cell      win_l, win_c, win_r, win_nv;
    logic [IDX_W-1:0]    win_pos;
    tta_pkg::t_cell      load_code;

    logic                div_start;
    tta_pkg::t_div_res   div_res;

    assign cols_e   = tta_pkg::clamp_len(r_grid_cols, tta_pkg::MAX_COLS);
    assign rows_e   = tta_pkg::clamp_len(r_grid_rows, tta_pkg::MAX_ROWS);
    assign cols_m1  = cols_e - LEN_W'(1);
    assign rows_m1  = rows_e - LEN_W'(1);
    assign limit_e  = (r_step_limit == '0) ? LIM_W'(1) : r_step_limit;

    assign line_len = (r_phase == PH_SOUTH) ? rows_e : cols_e;
    assign line_cnt = (r_phase == PH_SOUTH) ? cols_e : rows_e;
    assign len_m1   = line_len - LEN_W'(1);
    assign cnt_m1   = line_cnt - LEN_W'(1);
    assign k_m1     = r_k - LEN_W'(1);
    assign rk_m2    = r_rk - LEN_W'(2);
    assign mover    = (r_phase == PH_SOUTH) ? tta_pkg::CELL_SOUTH : tta_pkg::CELL_EAST;

    // read order along a line: last cell, then cells 0 .. last
    assign rd_idx   = (r_k == '0) ? len_m1[IDX_W-1:0] : k_m1[IDX_W-1:0];
    assign rd_addr  = (r_phase == PH_SOUTH) ? tta_pkg::cell_addr(rd_idx, r_line)
                                            : tta_pkg::cell_addr(r_line, rd_idx);

    assign accept    = start && !busy;
    assign size_wr   = i_cfg_we && (i_cfg_idx == tta_pkg::CFG_COLS ||
                                    i_cfg_idx == tta_pkg::CFG_ROWS);
    assign load_code = (i_cell_req == tta_pkg::CELL_BAD) ? tta_pkg::CELL_EMPTY : i_cell_req;

    assign busy        = r_state != S_IDLE;
    assign o_done      = r_done;
    assign o_steps     = r_step_cnt;
    assign o_limit_hit = r_moved;

    tta_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_load_pos),
        .i_divisor  (cols_e),
        .o_res      (div_res)
    );

    always_comb begin
        // window over the stream of read data, or the wrap-around tail
        n_wl    = r_wl;
        n_wc    = r_wc;
        n_save0 = r_save0;
        win_en  = 1'b0;
        win_l   = r_wl;
        win_c   = r_wc;
        win_r   = r_q;
        win_pos = rk_m2[IDX_W-1:0];
        if (r_rv) begin
            n_wl = r_wc;
            n_wc = r_q;
            if (r_rk == LEN_W'(1)) begin
                n_save0 = r_q;
            end
            if (r_rk >= LEN_W'(2)) begin
                win_en = 1'b1;
            end
        end
        if (r_state == S_TAIL) begin
            win_en  = 1'b1;
            win_r   = r_save0;
            win_pos = len_m1[IDX_W-1:0];
        end
        win_nv = tta_pkg::next_cell(win_l, win_c, win_r, mover);
        win_we = win_en && (win_nv != win_c);

        n_state    = r_state;
        n_phase    = r_phase;
        n_line     = r_line;
        n_k        = r_k;
        n_step_cnt = r_step_cnt;
        n_moved    = r_moved || win_we;
        n_done     = 1'b0;
        n_load_row = r_load_row;
        n_load_col = r_load_col;
        n_load_pos = r_load_pos;
        rd_en      = 1'b0;
        div_start  = 1'b0;
        mem_we     = win_we;
        mem_wd     = win_nv;
        mem_wa     = (r_phase == PH_SOUTH) ? tta_pkg::cell_addr(win_pos, r_line)
                                           : tta_pkg::cell_addr(r_line, win_pos);

        case (r_state)
            S_IDLE: begin
                if (size_wr) begin
                    div_start = 1'b1;
                    n_state   = S_RECALC;
                end else if (accept && !i_kind) begin
                    mem_we = 1'b1;
                    mem_wa = tta_pkg::cell_addr(r_load_row, r_load_col);
                    mem_wd = load_code;
                    if (LEN_W'(r_load_col) == cols_m1) begin
                        n_load_col = '0;
                        if (LEN_W'(r_load_row) == rows_m1) begin
                            n_load_row = '0;
                            n_load_pos = '0;
                        end else begin
                            n_load_row = r_load_row + IDX_W'(1);
                            n_load_pos = r_load_pos + POS_W'(1);
                        end
                    end else begin
                        n_load_col = r_load_col + IDX_W'(1);
                        n_load_pos = r_load_pos + POS_W'(1);
                    end
                end else if (accept) begin
                    n_load_row = '0;
                    n_load_col = '0;
                    n_load_pos = '0;
                    n_step_cnt = LIM_W'(1);
                    n_moved    = 1'b0;
                    n_phase    = PH_EAST;
                    n_line     = '0;
                    n_k        = '0;
                    n_state    = S_READ;
                end
            end
            S_RECALC: begin
                if (size_wr) begin
                    div_start = 1'b1;
                end else if (div_res.done) begin
                    if (div_res.quo < POS_W'(rows_e)) begin
                        n_load_row = div_res.quo[IDX_W-1:0];
                        n_load_col = div_res.rem[IDX_W-1:0];
                    end else begin
                        n_load_row = '0;
                        n_load_col = '0;
                        n_load_pos = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                rd_en = 1'b1;
                n_k   = r_k + LEN_W'(1);
                if (r_k == line_len) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_TAIL;
            end
            S_TAIL: begin
                n_k     = '0;
                n_state = S_READ;
                if (LEN_W'(r_line) != cnt_m1) begin
                    n_line = r_line + IDX_W'(1);
                end else if (r_phase == PH_EAST) begin
                    n_line  = '0;
                    n_phase = PH_SOUTH;
                end else if (!n_moved || r_step_cnt == limit_e) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_line     = '0;
                    n_phase    = PH_EAST;
                    n_step_cnt = r_step_cnt + LIM_W'(1);
                    n_moved    = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols  <= tta_pkg::DIM_CFG_W'(tta_pkg::MAX_COLS);
            r_grid_rows  <= tta_pkg::DIM_CFG_W'(tta_pkg::MAX_ROWS);
            r_step_limit <= LIM_W'(1048576);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tta_pkg::CFG_COLS:  r_grid_cols  <= i_cfg_data[tta_pkg::DIM_CFG_W-1:0];
                tta_pkg::CFG_ROWS:  r_grid_rows  <= i_cfg_data[tta_pkg::DIM_CFG_W-1:0];
                tta_pkg::CFG_LIMIT: r_step_limit <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_EAST;
            r_line     <= '0;
            r_k        <= '0;
            r_rv       <= 1'b0;
            r_step_cnt <= '0;
            r_moved    <= 1'b0;
            r_done     <= 1'b0;
            r_load_row <= '0;
            r_load_col <= '0;
            r_load_pos <= '0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_line     <= n_line;
            r_k        <= n_k;
            r_rv       <= rd_en;
            r_step_cnt <= n_step_cnt;
            r_moved    <= n_moved;
            r_done     <= n_done;
            r_load_row <= n_load_row;
            r_load_col <= n_load_col;
            r_load_pos <= n_load_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rk    <= r_k;
        r_wl    <= n_wl;
        r_wc    <= n_wc;
        r_save0 <= n_save0;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
    end

endmodule

@@ design/tta_checker.sv @@
// ----------------------------------------------------------------------------
// tta_checker
// Port-level checks on the traffic automaton, bound to the top level.
// ----------------------------------------------------------------------------
`include "toroidal_traffic_automaton_macros.svh"

module tta_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      i_kind,
    input logic                      i_cfg_we,
    input tta_pkg::t_cfg_idx         i_cfg_idx,
    input logic                      o_done,
    input logic [tta_pkg::LIM_W-1:0] o_steps
);

    `TTA_ASSERT_NOW(a_steps_nonzero, o_done, o_steps != '0)
    `TTA_ASSERT_NEXT(a_done_single, o_done, !o_done)
    `TTA_ASSERT_NEXT(a_run_goes_busy, start && !busy && i_kind && !i_cfg_we, busy)
    `TTA_ASSERT_NEXT(a_load_streams, start && !busy && !i_kind && !i_cfg_we, !busy && !o_done)
    `TTA_ASSERT_NEXT(a_size_write_busy,
        i_cfg_we && (i_cfg_idx == tta_pkg::CFG_COLS || i_cfg_idx == tta_pkg::CFG_ROWS), busy)

endmodule

bind toroidal_traffic_automaton tta_checker u_tta_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_kind    (i_kind),
    .i_cfg_we  (i_cfg_we),
    .i_cfg_idx (i_cfg_idx),
    .o_done    (o_done),
    .o_steps   (o_steps)
);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for toroidal_traffic_automaton. A directed script walks
// the edge cases on tiny grids, then random load/run phases cover small grids,
// a full-width row, a full-height column and very large step limits. Every
// run result is checked against scripted values or an in-bench grid model.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tta_pkg::*;

    localparam logic     KIND_LOAD = 1'b0;
    localparam logic     KIND_RUN  = 1'b1;
    localparam t_cfg_idx CFG_SPARE = 2'd3;

    localparam int RESET_CYCLES   = 6;
    localparam int QUIET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int ITEM_TARGET    = 700;
    localparam int MIN_RUNS       = 48;
    localparam int TIMEOUT_CYCLES = 2_000_000;

    typedef enum {ROW_CFG, ROW_LOAD, ROW_RUN} row_op_e;

    typedef struct {
        row_op_e          op;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] data;
        t_cell            code;
        bit               typed;
        logic [LIM_W-1:0] steps;
        logic             hit;
    } script_row_t;

    typedef struct {
        logic [LIM_W-1:0] steps;
        logic             hit;
    } settle_result_t;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             busy;
    logic             i_kind     = 1'b0;
    logic [1:0]       i_cell_req = 2'd0;
    logic             i_cfg_we   = 1'b0;
    t_cfg_idx         i_cfg_idx  = CFG_COLS;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             o_done;
    logic [LIM_W-1:0] o_steps;
    logic             o_limit_hit;

    toroidal_traffic_automaton DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_cell_req  (i_cell_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_steps     (o_steps),
        .o_limit_hit (o_limit_hit)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // grid model
    t_cell                grid [CELLS];
    bit                   written [CELLS];
    logic [DIM_CFG_W-1:0] cols_reg  = 9'd256;
    logic [DIM_CFG_W-1:0] rows_reg  = 9'd256;
    logic [LIM_W-1:0]     limit_reg = 21'h100000;
    int                   load_pos  = 0;
    bit                   last_hit  = 1'b0;

    settle_result_t settle_q [$];

    int mismatch_count = 0;
    int item_count     = 0;
    int run_count      = 0;
    int cycle_count    = 0;
    bit gaps_on        = 1'b1;

    script_row_t script [40] = '{
        '{ROW_CFG,  CFG_COLS,  21'd2,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_CFG,  CFG_ROWS,  21'd1,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_CFG,  CFG_LIMIT, 21'd1,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_EAST,  1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_RUN,  CFG_COLS,  21'd0,       CELL_EMPTY, 1'b1, 21'd1, 1'b1},
        '{ROW_CFG,  CFG_LIMIT, 21'd0,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_RUN,  CFG_COLS,  21'd0,       CELL_EMPTY, 1'b1, 21'd1, 1'b1},
        '{ROW_CFG,  CFG_LIMIT, 21'd5,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_BAD,   1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_BAD,   1'b0, 21'd0, 1'b0},
        '{ROW_RUN,  CFG_COLS,  21'd0,       CELL_EMPTY, 1'b1, 21'd1, 1'b0},
        '{ROW_CFG,  CFG_COLS,  21'h1FFE01,  CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_CFG,  CFG_ROWS,  21'd0,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_EAST,  1'b0, 21'd0, 1'b0},
        '{ROW_RUN,  CFG_COLS,  21'd0,       CELL_EMPTY, 1'b1, 21'd1, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_SOUTH, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_SOUTH, 1'b0, 21'd0, 1'b0},
        '{ROW_RUN,  CFG_COLS,  21'd0,       CELL_EMPTY, 1'b1, 21'd1, 1'b0},
        '{ROW_CFG,  CFG_ROWS,  21'd2,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_CFG,  CFG_LIMIT, 21'd3,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_SOUTH, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_RUN,  CFG_COLS,  21'd0,       CELL_EMPTY, 1'b1, 21'd3, 1'b1},
        '{ROW_CFG,  CFG_SPARE, 21'h1FFFFF,  CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_SOUTH, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_SOUTH, 1'b0, 21'd0, 1'b0},
        '{ROW_CFG,  CFG_LIMIT, 21'h100000,  CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_RUN,  CFG_COLS,  21'd0,       CELL_EMPTY, 1'b1, 21'd1, 1'b0},
        '{ROW_CFG,  CFG_LIMIT, 21'h1FFFFF,  CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_RUN,  CFG_COLS,  21'd0,       CELL_EMPTY, 1'b1, 21'd1, 1'b0},
        '{ROW_CFG,  CFG_COLS,  21'd3,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_CFG,  CFG_LIMIT, 21'd12,      CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_EAST,  1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_SOUTH, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_EAST,  1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_EMPTY, 1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_EAST,  1'b0, 21'd0, 1'b0},
        '{ROW_LOAD, CFG_COLS,  21'd0,       CELL_SOUTH, 1'b0, 21'd0, 1'b0},
        '{ROW_RUN,  CFG_COLS,  21'd0,       CELL_EMPTY, 1'b0, 21'd0, 1'b0}
    };

    function automatic int eff_cols();
        if (cols_reg == '0) begin
            return 1;
        end
        return (int'(cols_reg) > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic int eff_rows();
        if (rows_reg == '0) begin
            return 1;
        end
        return (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    // Advances the grid model by one transfer; returns 1 when a result is due.
    function automatic bit apply_item(input logic kind, input t_cell code,
                                      output settle_result_t res);
        t_cell line [MAX_DIM];
        int    cols;
        int    rows;
        int    total;
        int    p;
        int    addr;
        int    limit;
        int    count;
        int    r;
        int    c;
        int    n;
        bit    moved;
        cols      = eff_cols();
        rows      = eff_rows();
        total     = cols * rows;
        res.steps = '0;
        res.hit   = 1'b0;
        if (kind == KIND_LOAD) begin
            p    = (load_pos < total) ? load_pos : 0;
            addr = (p / cols) * MAX_COLS + p % cols;
            grid[addr]    = (code == CELL_BAD) ? CELL_EMPTY : code;
            written[addr] = 1'b1;
            load_pos = (p + 1 < total) ? p + 1 : 0;
            return 1'b0;
        end
        limit    = (limit_reg == '0) ? 1 : int'(limit_reg);
        load_pos = 0;
        count    = 0;
        moved    = 1'b1;
        while (count < limit && moved) begin
            count++;
            moved = 1'b0;
            for (r = 0; r < rows; r++) begin
                for (c = 0; c < cols; c++) begin
                    line[c] = grid[r * MAX_COLS + c];
                end
                for (c = 0; c < cols; c++) begin
                    n = (c + 1 < cols) ? c + 1 : 0;
                    if (line[c] == CELL_EAST && line[n] == CELL_EMPTY && n != c) begin
                        grid[r * MAX_COLS + n] = CELL_EAST;
                        grid[r * MAX_COLS + c] = CELL_EMPTY;
                        moved = 1'b1;
                    end
                end
            end
            for (c = 0; c < cols; c++) begin
                for (r = 0; r < rows; r++) begin
                    line[r] = grid[r * MAX_COLS + c];
                end
                for (r = 0; r < rows; r++) begin
                    n = (r + 1 < rows) ? r + 1 : 0;
                    if (line[r] == CELL_SOUTH && line[n] == CELL_EMPTY && n != r) begin
                        grid[n * MAX_COLS + c] = CELL_SOUTH;
                        grid[r * MAX_COLS + c] = CELL_EMPTY;
                        moved = 1'b1;
                    end
                end
            end
        end
        res.steps = LIM_W'(count);
        res.hit   = moved;
        return 1'b1;
    endfunction

    task automatic send_item(input logic kind, input t_cell code, input bit typed,
                             input logic [LIM_W-1:0] t_steps, input logic t_hit);
        settle_result_t res;
        int             gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 99) < 24) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_kind     <= kind;
        i_cell_req <= code;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        item_count++;
        if (apply_item(kind, code, res)) begin
            run_count++;
            last_hit = res.hit;
            if (typed) begin
                res.steps = t_steps;
                res.hit   = t_hit;
            end
            settle_q.push_back(res);
        end
    endtask

    task automatic load_random(input int fill);
        t_cell code;
        if ($urandom_range(0, 99) < fill) begin
            code = t_cell'($urandom_range(1, 2));
        end else begin
            code = ($urandom_range(0, 4) == 0) ? CELL_BAD : CELL_EMPTY;
        end
        send_item(KIND_LOAD, code, 1'b0, '0, 1'b0);
    endtask

    task automatic send_run();
        send_item(KIND_RUN, t_cell'($urandom_range(0, 3)), 1'b0, '0, 1'b0);
    endtask

    // register writes only with the block idle and nothing outstanding
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        start <= 1'b0;
        while (settle_q.size() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_COLS:  cols_reg  = data[DIM_CFG_W-1:0];
            CFG_ROWS:  rows_reg  = data[DIM_CFG_W-1:0];
            CFG_LIMIT: limit_reg = data[LIM_W-1:0];
            default: ;
        endcase
        repeat (QUIET_CYCLES) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end else if (i_rst_n && o_done) begin
            if (settle_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: steps %0d limit_hit %0b",
                             o_steps, o_limit_hit);
                end
            end else begin
                if (o_steps !== settle_q[0].steps || o_limit_hit !== settle_q[0].hit) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected steps %0d limit_hit %0b, got %0d %0b",
                                 settle_q[0].steps, settle_q[0].hit, o_steps, o_limit_hit);
                    end
                end
                void'(settle_q.pop_front());
            end
        end
    end

    initial begin : stimulus
        int phase;
        phase = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            case (script[i].op)
                ROW_CFG:  cfg_write(script[i].idx, script[i].data);
                ROW_LOAD: send_item(KIND_LOAD, script[i].code, 1'b0, '0, 1'b0);
                default:  send_item(KIND_RUN, t_cell'($urandom_range(0, 3)),
                                    script[i].typed, script[i].steps, script[i].hit);
            endcase
        end

        while (item_count < ITEM_TARGET || run_count < MIN_RUNS) begin : rand_phase
            logic [DIM_CFG_W-1:0] cols_val;
            logic [DIM_CFG_W-1:0] rows_val;
            int                   total;
            int                   nloads;
            int                   fill;
            int                   pick;
            int                   r;
            int                   c;
            bit                   wide;
            bit                   covered;
            gaps_on = !(phase >= 12 && phase < 22);
            wide    = (phase == 3 || phase == 8);
            if (phase == 3) begin
                cols_val = DIM_CFG_W'($urandom_range(256, 511));
                rows_val = DIM_CFG_W'($urandom_range(0, 1));
            end else if (phase == 8) begin
                cols_val = DIM_CFG_W'($urandom_range(0, 1));
                rows_val = DIM_CFG_W'($urandom_range(256, 511));
            end else begin
                cols_val = DIM_CFG_W'($urandom_range(0, 4));
                rows_val = DIM_CFG_W'($urandom_range(0, 4));
            end
            cfg_write(CFG_COLS, {12'($urandom), cols_val});
            cfg_write(CFG_ROWS, {12'($urandom), rows_val});
            cfg_write(CFG_LIMIT, CFG_W'($urandom_range(0, 40)));
            total = eff_cols() * eff_rows();
            fill  = $urandom_range(10, 90);
            pick  = $urandom_range(0, 9);
            if (wide || pick < 6) begin
                nloads = total;
            end else if (pick < 8) begin
                nloads = $urandom_range(1, total);
            end else if (pick == 8) begin
                nloads = total + $urandom_range(1, total);
            end else begin
                nloads = 0;
            end
            repeat (nloads) load_random(fill);

            // a run must never read a cell that was never loaded
            covered = 1'b1;
            for (r = 0; r < eff_rows(); r++) begin
                for (c = 0; c < eff_cols(); c++) begin
                    if (!written[r * MAX_COLS + c]) begin
                        covered = 1'b0;
                    end
                end
            end
            if (!covered) begin
                repeat (total) load_random(fill);
            end
            send_run();

            // loads queued behind a run in progress, then a follow-up run
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(0, total)) load_random(fill);
                send_run();
            end

            // settled grid: very large limits still report the first quiet step
            if (!last_hit && $urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, 2);
                if (pick == 0) begin
                    cfg_write(CFG_LIMIT, 21'h100000);
                end else if (pick == 1) begin
                    cfg_write(CFG_LIMIT, 21'h1FFFFF);
                end else begin
                    cfg_write(CFG_LIMIT, CFG_W'($urandom_range(41, 21'h1FFFFF)));
                end
                send_run();
            end
            phase++;
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (settle_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
